/* hw/rtl/hrss_pkg.sv */
// Package for the hash ring server selector: widths, field layout, register
// indexes, controller states and the command/status structs.
// Depends on nothing; every other file of the block imports it.
package hrss_pkg;

   // Table and field sizes.
   localparam int MAX_POINTS  = 4096;
   localparam int MAX_SERVERS = 256;
   localparam int SLOT_W      = $clog2(MAX_POINTS);
   localparam int CNT_W       = $clog2(MAX_POINTS) + 1;
   localparam int DIV_W       = $clog2(MAX_SERVERS) + 1;
   localparam int POS_W       = 32;
   localparam int SRV_W       = 8;
   localparam int HASH_W      = 32;

   // Request tdata layout, lowest field first, padded to whole bytes.
   localparam int SLOT_LSB    = 0;
   localparam int POS_LSB     = SLOT_LSB + SLOT_W;
   localparam int SRV_LSB     = POS_LSB + POS_W;
   localparam int HASH_LSB    = SRV_LSB + SRV_W;
   localparam int REQ_BITS    = HASH_LSB + HASH_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((SRV_W + 7) / 8) * 8;

   // Configuration port.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = CNT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVERS = 2'd2;

   // Codes carried by the request kind and the mode register.
   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_LOOKUP  = 1'b1;
   localparam logic MODE_RING   = 1'b0;
   localparam logic MODE_MODULO = 1'b1;

   // Remainder unit: two quotient bits per step.
   localparam int DIV_STEPS = HASH_W / 2;
   localparam int DSTEP_W   = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_FETCH_WAIT,
      ST_DIVIDE,
      ST_RESULT
   } hrss_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;       // latch a lookup request and prime search and divider
      logic write;       // store one ring point
      logic rd_mid;      // read the probe point and remember its index
      logic rd_final;    // read the point that owns the hash
      logic cmp;         // narrow the search window
      logic fetch_load;  // capture the owning server
      logic div_step;    // advance the remainder unit
      logic out_load;    // move the result into the output register
   } hrss_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic modulo_mode;
      logic ring_empty;
      logic search_open;
      logic div_last;
      logic out_free;
   } hrss_status_type;

endpackage

/* hw/rtl/hash_ring_server_select.sv */
// Hash ring server selector. A write request (tuser 0) stores one ring point,
// a position and a server number, in a 4096-entry table and gives no
// response; points must be written sorted by position and before they are
// looked up. A lookup request (tuser 1) in ring mode binary-searches the
// first point_count points for the first position not below the key hash,
// wrapping to point 0; each probe reads the point memory and then narrows
// the search window. An empty ring answers 0 with the empty flag. In modulo
// mode the remainder unit produces two bits per cycle. One request is worked
// on at a time; a finished response waits in an output register, and the
// next request is taken while it waits.
module hash_ring_server_select (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration writes.
   input  logic                             csr_we,
   input  logic [hrss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hrss_pkg::CSR_W-1:0]       csr_wdata,
   // Requests.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // point_slot, point_position, point_server, key_hash, zero padding
   input  logic [hrss_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  logic [0:0]                       req_tuser,
   // Responses.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // server_number
   output logic [hrss_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // ring_empty
   output logic [0:0]                       rsp_tuser
);
   import hrss_pkg::*;

   hrss_cmd_type    cmd;
   hrss_status_type status;

   hrss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   hrss_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A lookup request keeps the block busy on the following cycle.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == REQ_LOOKUP) |=> !req_tready)
      else $error("request taken right after a lookup");

   // A result is only loaded when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten before it was taken");

   // An empty ring always answers server 0.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("empty-ring response carries a server number");

endmodule

/* hw/rtl/hrss_divider.sv */
// Remainder unit of the hash ring server selector: restoring division of a
// 32-bit hash by a server count, two quotient bits per cycle while step is high.
// Depends on hrss_pkg.
module hrss_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        step,
   input  logic [hrss_pkg::HASH_W-1:0] dividend,
   input  logic [hrss_pkg::DIV_W-1:0]  divisor,
   output logic [hrss_pkg::SRV_W-1:0]  remainder,
   output logic                        last
);
   import hrss_pkg::*;

   logic [HASH_W-1:0]  quo_ff, quo_in;
   logic [SRV_W-1:0]   rem_ff, rem_in;
   logic [DSTEP_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]   r1, r1s, r2, r2s;

   // Two dependent compare-and-subtract stages on the partial remainder.
   always_comb begin
      r1  = {rem_ff, quo_ff[HASH_W-1]};
      r1s = (r1 >= divisor) ? r1 - divisor : r1;
      r2  = {r1s[SRV_W-1:0], quo_ff[HASH_W-2]};
      r2s = (r2 >= divisor) ? r2 - divisor : r2;
   end

   // Next values of the shift register, the remainder and the step count.
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         count_in = '0;
      end else if (step) begin
         quo_in   = {quo_ff[HASH_W-3:0], 2'b00};
         rem_in   = r2s[SRV_W-1:0];
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign remainder = rem_ff;
   assign last      = (count_ff == DSTEP_W'(DIV_STEPS - 1));

endmodule

/* hw/rtl/hrss_dpath.sv */
// Datapath of the hash ring server selector: configuration registers, the
// ring point memory, the binary search window, the remainder unit and the
// output register. Depends on hrss_pkg and hrss_divider.
module hrss_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [hrss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hrss_pkg::CSR_W-1:0]       csr_wdata,
   input  logic [hrss_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  hrss_pkg::hrss_cmd_type           cmd,
   output hrss_pkg::hrss_status_type        status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hrss_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]                       rsp_tuser
);
   import hrss_pkg::*;

   logic             mode_ff;
   logic [CNT_W-1:0] points_ff;
   logic [DIV_W-1:0] servers_ff;
   logic [CNT_W-1:0] n_sat;
   logic [DIV_W-1:0] d_sat;

   logic [POS_W-1:0] pos_mem [MAX_POINTS];
   logic [SRV_W-1:0] srv_mem [MAX_POINTS];
   logic [POS_W-1:0] rd_pos_ff;
   logic [SRV_W-1:0] rd_srv_ff;
   logic [SLOT_W-1:0] rd_addr, final_addr;

   logic [HASH_W-1:0] hash_ff;
   logic [CNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [SLOT_W-1:0] mid_ff;
   logic [SRV_W-1:0]  res_srv_ff;
   logic [SRV_W-1:0]  div_rem;
   logic              div_last;

   logic             rsp_valid_ff;
   logic [SRV_W-1:0] rsp_srv_ff, rsp_srv_in;
   logic             rsp_empty_ff, rsp_empty_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RING;
         points_ff  <= '0;
         servers_ff <= DIV_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:    mode_ff    <= csr_wdata[0];
            CSR_POINTS:  points_ff  <= csr_wdata[CNT_W-1:0];
            CSR_SERVERS: servers_ff <= csr_wdata[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   // Counts above the table or server range are saturated.
   assign n_sat = (points_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : points_ff;
   assign d_sat = (servers_ff > DIV_W'(MAX_SERVERS)) ? DIV_W'(MAX_SERVERS) : servers_ff;

   // Ring point memory: one write and one registered read each cycle.
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign final_addr = (lo_ff >= n_sat) ? '0 : lo_ff[SLOT_W-1:0];
   assign rd_addr    = cmd.rd_final ? final_addr : mid[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         pos_mem[req_tdata[SLOT_LSB +: SLOT_W]] <= req_tdata[POS_LSB +: POS_W];
         srv_mem[req_tdata[SLOT_LSB +: SLOT_W]] <= req_tdata[SRV_LSB +: SRV_W];
      end
      rd_pos_ff <= pos_mem[rd_addr];
      rd_srv_ff <= srv_mem[rd_addr];
   end

   // Search window: find the first point whose position is not below the hash.
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.start) begin
         lo_in = '0;
         hi_in = n_sat;
      end else if (cmd.cmp) begin
         if (rd_pos_ff < hash_ff) begin
            lo_in = CNT_W'(mid_ff) + 1'b1;
         end else begin
            hi_in = CNT_W'(mid_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.start) begin
         hash_ff <= req_tdata[HASH_LSB +: HASH_W];
      end
      if (cmd.rd_mid) begin
         mid_ff <= mid[SLOT_W-1:0];
      end
      if (cmd.fetch_load) begin
         res_srv_ff <= rd_srv_ff;
      end
   end

   // Remainder of the hash by the server count.
   hrss_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start),
      .step      (cmd.div_step),
      .dividend  (req_tdata[HASH_LSB +: HASH_W]),
      .divisor   (d_sat),
      .remainder (div_rem),
      .last      (div_last)
   );

   // Result selection by mode, with the empty-ring and zero-divisor cases.
   always_comb begin
      rsp_srv_in   = '0;
      rsp_empty_in = 1'b0;
      if (mode_ff == MODE_MODULO) begin
         rsp_srv_in = (d_sat == '0) ? '0 : div_rem;
      end else if (n_sat == '0) begin
         rsp_empty_in = 1'b1;
      end else begin
         rsp_srv_in = res_srv_ff;
      end
   end

   // Output register: holds one result until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_srv_ff   <= rsp_srv_in;
         rsp_empty_ff <= rsp_empty_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_TDATA_W'(rsp_srv_ff);
   assign rsp_tuser[0] = rsp_empty_ff;

   // Status back to the controller.
   assign status.modulo_mode = (mode_ff == MODE_MODULO);
   assign status.ring_empty  = (n_sat == '0);
   assign status.search_open = (lo_ff < hi_ff);
   assign status.div_last    = div_last;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

endmodule

/* hw/rtl/hrss_ctrl.sv */
// Controller of the hash ring server selector: accepts requests and steps
// the datapath through a ring search or a remainder calculation.
// Depends on hrss_pkg.
module hrss_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [0:0]                req_tuser,
   input  hrss_pkg::hrss_status_type status,
   output hrss_pkg::hrss_cmd_type    cmd
);
   import hrss_pkg::*;

   hrss_state_type state_ff, state_in;
   logic           accept;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser[0] == REQ_LOOKUP) begin
               if (status.modulo_mode) begin
                  state_in = ST_DIVIDE;
               end else if (status.ring_empty) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SEARCH_RD;
               end
            end
         end
         ST_SEARCH_RD: begin
            state_in = status.search_open ? ST_SEARCH_CMP : ST_FETCH_WAIT;
         end
         ST_SEARCH_CMP: state_in = ST_SEARCH_RD;
         ST_FETCH_WAIT: state_in = ST_RESULT;
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (req_tuser[0] == REQ_LOOKUP) begin
                  cmd.start = 1'b1;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_SEARCH_RD: begin
            if (status.search_open) begin
               cmd.rd_mid = 1'b1;
            end else begin
               cmd.rd_final = 1'b1;
            end
         end
         ST_SEARCH_CMP: cmd.cmp        = 1'b1;
         ST_FETCH_WAIT: cmd.fetch_load = 1'b1;
         ST_DIVIDE:     cmd.div_step   = 1'b1;
         ST_RESULT:     cmd.out_load   = status.out_free;
         default: ;
      endcase
   end

endmodule

/* tb/sv/tb_hash_ring_server_select.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the hash ring server selector: a directed table, a large-ring
// phase and random ring and modulo phases, each response checked against a local predictor
// or an expected value given in the table. Depends on hrss_pkg and hash_ring_server_select.
module tb_hash_ring_server_select;
   import hrss_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int IDLE_PCT      = 28;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 400;
   localparam int BIG_RING      = 256;

   typedef struct packed {
      logic [SRV_W-1:0] server;
      logic             empty;
   } selection_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_LOOKUP, ROW_CHECK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] csr_index;
      logic [CSR_W-1:0]     csr_value;
      logic [SLOT_W-1:0]    slot;
      logic [POS_W-1:0]     position;
      logic [SRV_W-1:0]     server;
      logic [HASH_W-1:0]    hash;
      selection_type        typed;
   } stim_row_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]       csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // point_slot, point_position, point_server, key_hash, zero padding
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // req_type
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // server_number
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // ring_empty
   logic [0:0]             rsp_tuser;

   // Local copy of the ring table and the registers.
   logic [POS_W-1:0] ring_pos_model [0:MAX_POINTS-1];
   logic [SRV_W-1:0] ring_srv_model [0:MAX_POINTS-1];
   logic             cfg_mode = MODE_RING;
   logic [CSR_W-1:0] cfg_points = '0;
   logic [8:0]       cfg_servers = 9'd1;

   selection_type expected_selections[$];
   selection_type want;
   stim_row_type  directed_rows[$];
   stim_row_type  row;

   bit          steady_flow = 1'b0;
   int unsigned holds_asked = 0;
   int unsigned holds_done = 0;
   int unsigned hold_left = 0;
   int unsigned mismatches = 0;
   int unsigned responses_checked = 0;
   int unsigned writes_sent = 0;
   int unsigned lookups_sent = 0;
   int unsigned csr_writes = 0;
   int unsigned random_items = 0;
   int unsigned phase = 0;
   int unsigned ring_size;
   logic        mode_pick;
   logic [CSR_W-1:0] csr_pick;

   hash_ring_server_select i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Expected response for a lookup under the current registers and table.
   function automatic selection_type select_server(input logic [HASH_W-1:0] hash);
      selection_type     sel;
      int unsigned       lo, hi, mid, n, d;
      logic [HASH_W-1:0] rem;
      sel = '0;
      if (cfg_mode == MODE_RING) begin
         n = (cfg_points > MAX_POINTS) ? MAX_POINTS : cfg_points;
         if (n == 0) begin
            sel.empty = 1'b1;
         end else begin
            lo = 0;
            hi = n;
            while (lo < hi) begin
               mid = lo + (hi - lo) / 2;
               if (ring_pos_model[mid] < hash) lo = mid + 1;
               else hi = mid;
            end
            if (lo >= n) lo = 0;
            sel.server = ring_srv_model[lo];
         end
      end else begin
         d = (cfg_servers > MAX_SERVERS) ? MAX_SERVERS : cfg_servers;
         if (d != 0) begin
            rem = hash % d;
            sel.server = rem[SRV_W-1:0];
         end
      end
      return sel;
   endfunction

   // Offer one request, wait for it to be taken, then update the model.
   task automatic send_request(input logic kind, input logic [SLOT_W-1:0] slot,
                               input logic [POS_W-1:0] position,
                               input logic [SRV_W-1:0] server,
                               input logic [HASH_W-1:0] hash,
                               input bit typed, input selection_type typed_sel);
      logic [REQ_TDATA_W-1:0] data;
      int unsigned            gap;
      data = '0;
      data[SLOT_LSB +: SLOT_W] = slot;
      data[POS_LSB +: POS_W]   = position;
      data[SRV_LSB +: SRV_W]   = server;
      data[HASH_LSB +: HASH_W] = hash;
      gap = 0;
      if (!steady_flow && $urandom_range(99) < IDLE_PCT)
         gap = ($urandom_range(7) == 0) ? $urandom_range(40, 2) : 1;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == REQ_WRITE) begin
         ring_pos_model[slot] = position;
         ring_srv_model[slot] = server;
         writes_sent++;
      end else begin
         expected_selections.push_back(typed ? typed_sel : select_server(hash));
         lookups_sent++;
      end
   endtask

   task automatic load_point(input logic [SLOT_W-1:0] slot, input logic [POS_W-1:0] position,
                             input logic [SRV_W-1:0] server);
      send_request(REQ_WRITE, slot, position, server, $urandom(), 1'b0, '0);
   endtask

   task automatic look_up(input logic [HASH_W-1:0] hash);
      send_request(REQ_LOOKUP, $urandom_range(MAX_POINTS - 1), $urandom(),
                   $urandom_range(255), hash, 1'b0, '0);
   endtask

   // Stop offering, wait for every outstanding response, then let the block settle.
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_selections.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      drain_requests();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_MODE:    cfg_mode = value[0];
         CSR_POINTS:  cfg_points = value;
         CSR_SERVERS: cfg_servers = value[8:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Write n points into slots 0 to n-1 in ascending position order, some repeated.
   task automatic load_sorted_ring(input int unsigned n);
      logic [63:0] position;
      logic [31:0] span;
      span = 32'hFFFF_FFFF / (n + 1);
      position = $urandom_range(span, 0);
      for (int unsigned i = 0; i < n; i++) begin
         load_point(i[SLOT_W-1:0], position[POS_W-1:0], $urandom_range(255));
         position += ($urandom_range(7) == 0) ? 0 : $urandom_range(span, 1);
      end
   endtask

   // Lookup hashes: edges of the range, loaded positions and their neighbours, or noise.
   function automatic logic [HASH_W-1:0] pick_hash(input int unsigned n);
      logic [HASH_W-1:0] near;
      near = (n != 0) ? ring_pos_model[$urandom_range(n - 1, 0)] : $urandom();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return near;
         4: return near + 1;
         5: return near - 1;
         default: return $urandom();
      endcase
   endfunction

   function automatic void add_write(input logic [SLOT_W-1:0] slot,
                                     input logic [POS_W-1:0] position,
                                     input logic [SRV_W-1:0] server);
      stim_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.slot = slot;
      r.position = position;
      r.server = server;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_lookup(input logic [HASH_W-1:0] hash);
      stim_row_type r;
      r = '0;
      r.kind = ROW_LOOKUP;
      r.hash = hash;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_check(input logic [HASH_W-1:0] hash,
                                     input logic [SRV_W-1:0] server, input logic empty);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CHECK;
      r.hash = hash;
      r.typed.server = server;
      r.typed.empty = empty;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_W-1:0] value);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.csr_index = index;
      r.csr_value = value;
      directed_rows.push_back(r);
   endfunction

   // Response side: check each response taken and drive the ready, with random
   // stalls and, on request, one long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_selections.size() == 0) begin
            $display("%0t: unexpected response, actual server %0d empty %0b",
                     $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_selections.pop_front();
            if (rsp_tdata[SRV_W-1:0] !== want.server || rsp_tuser[0] !== want.empty) begin
               $display("%0t: mismatch, expected server %0d empty %0b, actual server %0d empty %0b",
                        $time, want.server, want.empty, rsp_tdata, rsp_tuser);
               mismatches++;
            end
            responses_checked++;
         end
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty ring, a small ring with a repeated position and
      // wrap-around, then the modulo edge cases and register masking.
      add_check(32'h0000_0000, 8'h00, 1'b1);
      add_check(32'hFFFF_FFFF, 8'h00, 1'b1);
      add_write(0, 32'h0000_0000, 8'h11);
      add_write(1, 32'h8000_0000, 8'hA5);
      add_write(2, 32'h8000_0000, 8'h5A);
      add_write(3, 32'hFFFF_FFFE, 8'hFF);
      add_csr(CSR_POINTS, 4);
      add_lookup(32'h0000_0000);
      add_lookup(32'h8000_0000);
      add_lookup(32'h8000_0001);
      add_lookup(32'hFFFF_FFFF);
      add_csr(CSR_POINTS, 1);
      add_lookup(32'hFFFF_FFFF);
      add_csr(CSR_MODE, MODE_MODULO);
      add_check(32'hFFFF_FFFF, 8'h00, 1'b0);
      add_csr(CSR_SERVERS, 0);
      add_check(32'h1234_5678, 8'h00, 1'b0);
      add_csr(CSR_SERVERS, 256);
      add_check(32'hFFFF_FFFF, 8'hFF, 1'b0);
      add_csr(CSR_SERVERS, 13'h1FFF);
      add_check(32'h0000_01FF, 8'hFF, 1'b0);
      add_csr(CSR_SERVERS, 7);
      add_lookup(32'hFFFF_FFFF);
      add_csr(CSR_SPARE, 13'h1FFF);
      add_lookup(32'h0000_0100);
      add_csr(CSR_MODE, 13'h1FFE);
      add_csr(CSR_POINTS, 0);
      add_check(32'h5555_AAAA, 8'h00, 1'b1);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_WRITE:  load_point(row.slot, row.position, row.server);
            ROW_LOOKUP: look_up(row.hash);
            ROW_CHECK:  send_request(REQ_LOOKUP, '0, '0, '0, row.hash, 1'b1, row.typed);
            default:    write_csr(row.csr_index, row.csr_value);
         endcase
      end

      // A large ring searched under a long hold-off on the response side.
      load_sorted_ring(BIG_RING);
      write_csr(CSR_MODE, MODE_RING);
      write_csr(CSR_POINTS, BIG_RING);
      holds_asked++;
      repeat (60) look_up(pick_hash(BIG_RING));

      // Random phases: load a sorted ring, set the registers, then a burst of
      // lookups mixed with in-order rewrites and writes beyond the live ring.
      while (random_items < RANDOM_ITEMS) begin
         phase++;
         steady_flow = (phase == 2);
         case ($urandom_range(11))
            0: ring_size = 0;
            1: ring_size = 1;
            2: ring_size = $urandom_range(200, 65);
            default: ring_size = $urandom_range(16, 2);
         endcase
         load_sorted_ring(ring_size);
         random_items += ring_size;
         repeat ($urandom_range(3)) begin
            load_point($urandom_range(MAX_POINTS - 1, ring_size), $urandom(),
                       $urandom_range(255));
            random_items++;
         end

         mode_pick = ($urandom_range(9) < 4) ? MODE_MODULO : MODE_RING;
         csr_pick = $urandom();
         csr_pick[0] = mode_pick;
         write_csr(CSR_MODE, csr_pick);
         write_csr(CSR_POINTS, ring_size);
         case ($urandom_range(9))
            0: csr_pick = 0;
            1: csr_pick = 1;
            2: csr_pick = 256;
            3: csr_pick = 511;
            4: csr_pick = $urandom_range(511, 257);
            default: csr_pick = $urandom_range(255, 1);
         endcase
         csr_pick[CSR_W-1:9] = $urandom();
         write_csr(CSR_SERVERS, csr_pick);
         if ($urandom_range(7) == 0) write_csr(CSR_SPARE, $urandom());

         if (phase == 3) holds_asked++;
         repeat ($urandom_range(30, 10)) begin
            case ($urandom_range(7))
               0: begin
                  if (ring_size != 0) begin
                     // Same position, new owner: the ring stays sorted.
                     csr_pick = $urandom_range(ring_size - 1, 0);
                     load_point(csr_pick[SLOT_W-1:0], ring_pos_model[csr_pick],
                                $urandom_range(255));
                  end else begin
                     look_up(pick_hash(0));
                  end
               end
               1: load_point($urandom_range(MAX_POINTS - 1, ring_size), $urandom(),
                             $urandom_range(255));
               default: look_up(pick_hash(ring_size));
            endcase
            random_items++;
         end
      end
      steady_flow = 1'b0;

      drain_requests();
      $display("Run covered %0d point writes, %0d lookups and %0d register writes over %0d phases;",
               writes_sent, lookups_sent, csr_writes, phase);
      $display("%0d responses checked, rings from empty to %0d points, divisors 0 to oversized.",
               responses_checked, BIG_RING);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      #(4_000_000);
      $display("%0t: watchdog expired with %0d responses outstanding", $time,
               expected_selections.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
